// ===== design/ibot_pkg.sv =====
// ----------------------------------------------------------------------------
// ibot_pkg
// Shared types, codes and helpers of the image buffer ownership tracker.
// ----------------------------------------------------------------------------
package ibot_pkg;

	localparam int MAX_IMAGES_DEF = 16;
	localparam int RESULT_CAP     = 16;
	localparam int ID_W           = 32;
	localparam int STATUS_W       = 3;

	// configuration register indexes
	localparam logic [0:0] CFG_PRODUCER_SIDE = 1'b0;
	localparam logic [0:0] CFG_CHECKS        = 1'b1;

	typedef enum logic [2:0] {
		CMD_ADD     = 3'd0,
		CMD_REMOVE  = 3'd1,
		CMD_ACQUIRE = 3'd2,
		CMD_PRESENT = 3'd3,
		CMD_RELEASE = 3'd4,
		CMD_FLUSH   = 3'd5
	} cmd_t;

	typedef enum logic [3:0] {
		ERR_OK                    = 4'd0,
		ERR_ADD_DUP               = 4'd1,
		ERR_REMOVE_ABSENT         = 4'd2,
		ERR_REMOVE_PRESENTED      = 4'd3,
		ERR_PRESENT_ABSENT        = 4'd4,
		ERR_PRESENT_NOT_ACQUIRED  = 4'd5,
		ERR_PRESENT_PRESENTED     = 4'd6,
		ERR_RELEASE_ABSENT        = 4'd7,
		ERR_RELEASE_NOT_ACQUIRED  = 4'd8,
		ERR_RELEASE_NOT_PRESENTED = 4'd9,
		ERR_POOL_FULL             = 4'd10
	} err_t;

	typedef enum logic [1:0] {
		PLACE_PROD_WAIT = 2'd0,
		PLACE_PROD_HELD = 2'd1,
		PLACE_CONS_WAIT = 2'd2,
		PLACE_CONS_HELD = 2'd3
	} place_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EXEC,
		ST_CMP,
		ST_ACQ_RQ,
		ST_ACQ_RS,
		ST_ACQ_DO,
		ST_FL_CHK,
		ST_FL_RQ,
		ST_FL_RS,
		ST_FL_DO,
		ST_EMIT
	} state_t;

	typedef struct packed {
		place_t            place;
		logic [ID_W-1:0]   id;
	} slot_t;

	typedef struct packed {
		logic                last;
		logic                flushed;
		logic [STATUS_W-1:0] status;
		logic                completion;
		logic                acquired;
		err_t                err;
		logic [ID_W-1:0]     id;
	} res_t;

	function automatic res_t make_res(input logic [ID_W-1:0] id, input err_t err,
			input logic acq, input logic comp, input logic [STATUS_W-1:0] st,
			input logic fl, input logic last);
		res_t r;
		r.id         = id;
		r.err        = err;
		r.acquired   = acq;
		r.completion = comp;
		r.status     = st;
		r.flushed    = fl;
		r.last       = last;
		return r;
	endfunction

endpackage

// ===== design/image_buffer_ownership_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// image_buffer_ownership_tracker_unit
// Ownership tracker for a pool of image buffers shared by producer and consumer.
// ----------------------------------------------------------------------------
// One command is worked at a time. Add, remove, present and release first scan
// the slot memory for the image id, one entry per cycle; a remove of a
// producer-waiting image adds a compaction walk over the producer queue memory.
// Acquire reads the queue, then the slot, unless the queue is empty; a flush
// reads the consumer queue, then the slot, for each completed image, capped at
// 16 completions. The result register lets the next command be taken while
// a result still waits. No clearing pass after reset: slot valid and
// present-pending bits are flip-flops, the queues use counts.
// ----------------------------------------------------------------------------
module image_buffer_ownership_tracker_unit
	import ibot_pkg::*;
#(
	parameter int MAX_IMAGES = MAX_IMAGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// command[2:0], image_id[34:3], release_status[37:35], zero fill
	input  logic [39:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// result_id[31:0], error_code[35:32], acquired[36], completion[37],
	// completion_status[40:38], flushed[41], zero fill
	output logic [47:0] m_tdata,
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [0:0]  cfg_data
);

	localparam int IDXW = $clog2(MAX_IMAGES);
	localparam int CNTW = $clog2(MAX_IMAGES + 1);

	// index arithmetic on the circular queues
	function automatic logic [IDXW-1:0] wrap_inc(input logic [IDXW-1:0] p);
		return (p == IDXW'(MAX_IMAGES - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [IDXW-1:0] tail_of(input logic [IDXW-1:0] h,
			input logic [CNTW-1:0] c);
		logic [CNTW:0] s;
		s = (CNTW+1)'(h) + (CNTW+1)'(c);
		return (s >= (CNTW+1)'(MAX_IMAGES)) ? IDXW'(s - (CNTW+1)'(MAX_IMAGES)) : IDXW'(s);
	endfunction

	state_t state_q, state_d;

	cmd_t                cmd_q, cmd_d;
	logic [ID_W-1:0]     id_q, id_d;
	logic [STATUS_W-1:0] status_q, status_d;
	logic                producer_side_q, checks_q;

	logic [MAX_IMAGES-1:0] valid_q, valid_d, pend_q, pend_d;
	logic [IDXW-1:0] ph_q, ph_d, ch_q, ch_d;
	logic [CNTW-1:0] pc_q, pc_d, cc_q, cc_d;

	// slot scan results
	logic [CNTW-1:0] scan_q, scan_d;
	logic            hit_q, hit_d, free_q, free_d;
	logic [IDXW-1:0] hit_idx_q, hit_idx_d, free_idx_q, free_idx_d;
	place_t          hit_place_q, hit_place_d;
	logic [IDXW-1:0] cmp_idx;

	// compaction walk and flush bookkeeping
	logic [IDXW-1:0] rp_q, rp_d, wp_q, wp_d;
	logic [CNTW-1:0] ci_q, ci_d, cj_q, cj_d;
	logic            cmp_v_s1, cmp_v_d;
	logic [IDXW-1:0] fl_idx_q, fl_idx_d;
	logic [CNTW-1:0] fl_left_q, fl_left_d;
	logic            more_q, more_d;

	res_t res_q, res_d, out_q;
	logic out_valid_q, emit_en, can_emit;

	// memory ports
	logic            slot_we, slot_re;
	logic [IDXW-1:0] slot_waddr, slot_raddr;
	slot_t           slot_wdata, slot_rdata;
	logic            pq_we, pq_re, cq_we, cq_re;
	logic [IDXW-1:0] pq_waddr, pq_raddr, pq_wdata, pq_rdata;
	logic [IDXW-1:0] cq_waddr, cq_raddr, cq_wdata, cq_rdata;

	cmd_t in_cmd;
	assign in_cmd = cmd_t'(s_tdata[2:0]);

	ibot_ram #(.WIDTH($bits(slot_t)), .DEPTH(MAX_IMAGES)) u_slot_ram (
		.clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
		.re(slot_re), .raddr(slot_raddr), .rdata(slot_rdata)
	);

	ibot_ram #(.WIDTH(IDXW), .DEPTH(MAX_IMAGES)) u_pq_ram (
		.clk(clk), .we(pq_we), .waddr(pq_waddr), .wdata(pq_wdata),
		.re(pq_re), .raddr(pq_raddr), .rdata(pq_rdata)
	);

	ibot_ram #(.WIDTH(IDXW), .DEPTH(MAX_IMAGES)) u_cq_ram (
		.clk(clk), .we(cq_we), .waddr(cq_waddr), .wdata(cq_wdata),
		.re(cq_re), .raddr(cq_raddr), .rdata(cq_rdata)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign can_emit = !out_valid_q || m_tready;
	assign cmp_idx  = IDXW'(scan_q - 1'b1);

	// producer errors read as ok while checking is off
	function automatic err_t perr(input logic chk, input err_t code);
		return chk ? code : ERR_OK;
	endfunction

	always_comb begin
		state_d     = state_q;
		cmd_d       = cmd_q;
		id_d        = id_q;
		status_d    = status_q;
		valid_d     = valid_q;
		pend_d      = pend_q;
		ph_d        = ph_q;
		pc_d        = pc_q;
		ch_d        = ch_q;
		cc_d        = cc_q;
		scan_d      = scan_q;
		hit_d       = hit_q;
		hit_idx_d   = hit_idx_q;
		hit_place_d = hit_place_q;
		free_d      = free_q;
		free_idx_d  = free_idx_q;
		rp_d        = rp_q;
		wp_d        = wp_q;
		ci_d        = ci_q;
		cj_d        = cj_q;
		cmp_v_d     = 1'b0;
		fl_idx_d    = fl_idx_q;
		fl_left_d   = fl_left_q;
		more_d      = more_q;
		res_d       = res_q;
		emit_en     = 1'b0;
		slot_we     = 1'b0;
		slot_re     = 1'b0;
		slot_waddr  = hit_idx_q;
		slot_raddr  = scan_q[IDXW-1:0];
		slot_wdata  = '{place: PLACE_PROD_HELD, id: id_q};
		pq_we       = 1'b0;
		pq_re       = 1'b0;
		pq_waddr    = tail_of(ph_q, pc_q);
		pq_raddr    = ph_q;
		pq_wdata    = hit_idx_q;
		cq_we       = 1'b0;
		cq_re       = 1'b0;
		cq_waddr    = tail_of(ch_q, cc_q);
		cq_raddr    = ch_q;
		cq_wdata    = hit_idx_q;

		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd_d    = in_cmd;
					id_d     = s_tdata[34:3];
					status_d = s_tdata[37:35];
					scan_d   = '0;
					hit_d    = 1'b0;
					free_d   = 1'b0;
					more_d   = 1'b0;
					unique case (in_cmd)
						CMD_ADD, CMD_REMOVE, CMD_PRESENT, CMD_RELEASE: state_d = ST_SCAN;
						CMD_ACQUIRE: state_d = ST_ACQ_RQ;
						CMD_FLUSH:   state_d = ST_FL_CHK;
						default: begin
							res_d   = make_res(s_tdata[34:3], ERR_OK, 1'b0, 1'b0, '0, 1'b0, 1'b1);
							state_d = ST_EMIT;
						end
					endcase
				end
			end

			ST_SCAN: begin
				if (scan_q < CNTW'(MAX_IMAGES)) begin
					slot_re    = 1'b1;
					slot_raddr = scan_q[IDXW-1:0];
				end
				if (scan_q != '0) begin
					if (valid_q[cmp_idx] && slot_rdata.id == id_q) begin
						hit_d       = 1'b1;
						hit_idx_d   = cmp_idx;
						hit_place_d = slot_rdata.place;
					end
					if (!valid_q[cmp_idx] && !free_q) begin
						free_d     = 1'b1;
						free_idx_d = cmp_idx;
					end
				end
				if (scan_q == CNTW'(MAX_IMAGES)) begin
					state_d = ST_EXEC;
				end else begin
					scan_d = scan_q + 1'b1;
				end
			end

			ST_EXEC: begin
				state_d = ST_EMIT;
				res_d   = make_res(id_q, ERR_OK, 1'b0, 1'b0, '0, 1'b0, 1'b1);
				unique case (cmd_q)
					CMD_ADD: begin
						if (hit_q) begin
							res_d.err = perr(checks_q, ERR_ADD_DUP);
						end else if (!free_q) begin
							res_d.err = ERR_POOL_FULL;
						end else begin
							valid_d[free_idx_q] = 1'b1;
							pend_d[free_idx_q]  = 1'b0;
							slot_we    = 1'b1;
							slot_waddr = free_idx_q;
							slot_wdata = '{place: producer_side_q ? PLACE_PROD_WAIT
								: PLACE_PROD_HELD, id: id_q};
							if (producer_side_q && pc_q < CNTW'(MAX_IMAGES)) begin
								pq_we    = 1'b1;
								pq_wdata = free_idx_q;
								pc_d     = pc_q + 1'b1;
							end
						end
					end
					CMD_REMOVE: begin
						if (!hit_q) begin
							res_d.err = perr(checks_q, ERR_REMOVE_ABSENT);
						end else if (hit_place_q == PLACE_CONS_WAIT
								|| hit_place_q == PLACE_CONS_HELD) begin
							res_d.err = perr(checks_q, ERR_REMOVE_PRESENTED);
						end else begin
							valid_d[hit_idx_q] = 1'b0;
							pend_d[hit_idx_q]  = 1'b0;
							if (hit_place_q == PLACE_PROD_WAIT) begin
								// drop the entry from the producer queue
								rp_d    = ph_q;
								wp_d    = ph_q;
								ci_d    = '0;
								cj_d    = '0;
								state_d = ST_CMP;
							end
						end
					end
					CMD_PRESENT: begin
						if (!hit_q) begin
							res_d.err = perr(checks_q, ERR_PRESENT_ABSENT);
						end else if (hit_place_q == PLACE_PROD_WAIT) begin
							res_d.err = perr(checks_q, ERR_PRESENT_NOT_ACQUIRED);
						end else if (hit_place_q != PLACE_PROD_HELD) begin
							res_d.err = perr(checks_q, ERR_PRESENT_PRESENTED);
						end else begin
							slot_we    = 1'b1;
							slot_wdata = '{place: producer_side_q ? PLACE_CONS_HELD
								: PLACE_CONS_WAIT, id: id_q};
							if (!producer_side_q && cc_q < CNTW'(MAX_IMAGES)) begin
								cq_we = 1'b1;
								cc_d  = cc_q + 1'b1;
							end
							pend_d[hit_idx_q] = 1'b1;
						end
					end
					CMD_RELEASE: begin
						if (!hit_q) begin
							res_d.err = ERR_RELEASE_ABSENT;
						end else if (hit_place_q == PLACE_CONS_WAIT) begin
							res_d.err = ERR_RELEASE_NOT_ACQUIRED;
						end else if (hit_place_q != PLACE_CONS_HELD) begin
							res_d.err = ERR_RELEASE_NOT_PRESENTED;
						end else begin
							slot_we    = 1'b1;
							slot_wdata = '{place: producer_side_q ? PLACE_PROD_WAIT
								: PLACE_PROD_HELD, id: id_q};
							if (producer_side_q && pc_q < CNTW'(MAX_IMAGES)) begin
								pq_we = 1'b1;
								pc_d  = pc_q + 1'b1;
							end
							res_d.completion  = pend_q[hit_idx_q];
							res_d.status      = pend_q[hit_idx_q] ? status_q : '0;
							pend_d[hit_idx_q] = 1'b0;
						end
					end
					default: begin
					end
				endcase
			end

			ST_CMP: begin
				if (cmp_v_s1 && pq_rdata != hit_idx_q) begin
					pq_we    = 1'b1;
					pq_waddr = wp_q;
					pq_wdata = pq_rdata;
					wp_d     = wrap_inc(wp_q);
					cj_d     = cj_q + 1'b1;
				end
				if (ci_q < pc_q) begin
					pq_re    = 1'b1;
					pq_raddr = rp_q;
					rp_d     = wrap_inc(rp_q);
					ci_d     = ci_q + 1'b1;
					cmp_v_d  = 1'b1;
				end else if (!cmp_v_s1) begin
					pc_d    = cj_q;
					state_d = ST_EMIT;
				end
			end

			ST_ACQ_RQ: begin
				if ((producer_side_q ? pc_q : cc_q) == '0) begin
					res_d   = make_res('0, ERR_OK, 1'b0, 1'b0, '0, 1'b0, 1'b1);
					state_d = ST_EMIT;
				end else begin
					pq_re   = producer_side_q;
					cq_re   = !producer_side_q;
					state_d = ST_ACQ_RS;
				end
			end

			ST_ACQ_RS: begin
				slot_re    = 1'b1;
				slot_raddr = producer_side_q ? pq_rdata : cq_rdata;
				fl_idx_d   = slot_raddr;
				state_d    = ST_ACQ_DO;
			end

			ST_ACQ_DO: begin
				slot_we    = 1'b1;
				slot_waddr = fl_idx_q;
				slot_wdata = '{place: producer_side_q ? PLACE_PROD_HELD
					: PLACE_CONS_HELD, id: slot_rdata.id};
				if (producer_side_q) begin
					ph_d = wrap_inc(ph_q);
					pc_d = pc_q - 1'b1;
				end else begin
					ch_d = wrap_inc(ch_q);
					cc_d = cc_q - 1'b1;
				end
				res_d   = make_res(slot_rdata.id, ERR_OK, 1'b1, 1'b0, '0, 1'b0, 1'b1);
				state_d = ST_EMIT;
			end

			ST_FL_CHK: begin
				if (producer_side_q || cc_q == '0) begin
					res_d   = make_res('0, ERR_OK, 1'b0, 1'b0, '0, 1'b0, 1'b1);
					state_d = ST_EMIT;
				end else begin
					fl_left_d = (int'(cc_q) > RESULT_CAP) ? CNTW'(RESULT_CAP) : cc_q;
					state_d   = ST_FL_RQ;
				end
			end

			ST_FL_RQ: begin
				cq_re   = 1'b1;
				state_d = ST_FL_RS;
			end

			ST_FL_RS: begin
				slot_re    = 1'b1;
				slot_raddr = cq_rdata;
				fl_idx_d   = cq_rdata;
				state_d    = ST_FL_DO;
			end

			ST_FL_DO: begin
				slot_we    = 1'b1;
				slot_waddr = fl_idx_q;
				slot_wdata = '{place: PLACE_PROD_HELD, id: slot_rdata.id};
				pend_d[fl_idx_q] = 1'b0;
				ch_d      = wrap_inc(ch_q);
				cc_d      = cc_q - 1'b1;
				fl_left_d = fl_left_q - 1'b1;
				more_d    = (fl_left_q != CNTW'(1));
				res_d     = make_res(slot_rdata.id, ERR_OK, 1'b0, pend_q[fl_idx_q], '0,
					pend_q[fl_idx_q], fl_left_q == CNTW'(1));
				state_d   = ST_EMIT;
			end

			ST_EMIT: begin
				if (can_emit) begin
					emit_en = 1'b1;
					state_d = more_q ? ST_FL_RQ : ST_IDLE;
				end
			end

			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			pend_q      <= '0;
			ph_q        <= '0;
			pc_q        <= '0;
			ch_q        <= '0;
			cc_q        <= '0;
			cmp_v_s1    <= 1'b0;
			more_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_q  <= valid_d;
			pend_q   <= pend_d;
			ph_q     <= ph_d;
			pc_q     <= pc_d;
			ch_q     <= ch_d;
			cc_q     <= cc_d;
			cmp_v_s1 <= cmp_v_d;
			more_q   <= more_d;
			if (emit_en) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			producer_side_q <= 1'b0;
			checks_q        <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PRODUCER_SIDE: producer_side_q <= cfg_data[0];
				CFG_CHECKS:        checks_q        <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// payload registers: no reset needed
	always_ff @(posedge clk) begin
		cmd_q       <= cmd_d;
		id_q        <= id_d;
		status_q    <= status_d;
		scan_q      <= scan_d;
		hit_q       <= hit_d;
		hit_idx_q   <= hit_idx_d;
		hit_place_q <= hit_place_d;
		free_q      <= free_d;
		free_idx_q  <= free_idx_d;
		rp_q        <= rp_d;
		wp_q        <= wp_d;
		ci_q        <= ci_d;
		cj_q        <= cj_d;
		fl_idx_q    <= fl_idx_d;
		fl_left_q   <= fl_left_d;
		res_q       <= res_d;
		if (emit_en) begin
			out_q <= res_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_q.last;
	assign m_tdata  = {6'b0, out_q.flushed, out_q.status, out_q.completion,
		out_q.acquired, out_q.err, out_q.id};

`ifndef SYNTHESIS
	// queue fill never passes the pool size
	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= CNTW'(MAX_IMAGES) && cc_q <= CNTW'(MAX_IMAGES))
		else $error("wait queue count out of range");

	// a new result never overwrites one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit_en |-> (!out_valid_q || m_tready))
		else $error("result register overwritten");

	// a scan hit always names a live slot
	a_hit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && hit_q) |-> valid_q[hit_idx_q])
		else $error("scan hit on an empty slot");
`endif

endmodule

// ===== design/ibot_ram.sv =====
// ----------------------------------------------------------------------------
// ibot_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module ibot_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench of the image buffer ownership tracker: a scoreboard
// predicts every result from its own model of the slot pool and wait queues,
// and a monitor compares each returned result against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
	import ibot_pkg::*;

	typedef struct {
		cmd_t       cmd;
		logic [31:0] id;
		logic [2:0]  st;
	} command_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic        m_tlast;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [0:0]  cfg_data;

	image_buffer_ownership_tracker_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// commands waiting for the driver, and results the pool model owes
	command_t command_q[$];
	res_t     due_results[$];

	// scoreboard copy of the tracker state and registers
	logic        mdl_producer_side;
	logic        mdl_checks;
	logic        mdl_valid [16];
	logic [31:0] mdl_id    [16];
	place_t      mdl_place [16];
	logic        mdl_pend  [16];
	int          mdl_prod_q[$];
	int          mdl_cons_q[$];

	int          send_idle_pct;
	int          recv_idle_pct;
	int          accepted_results;
	int          errors;
	logic [31:0] id_pool [12];
	command_t    drv_item;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

	task automatic post_result(input logic [31:0] id, input err_t err, input logic acq,
			input logic comp, input logic [2:0] st, input logic fl, input logic lst);
		res_t r;
		r.id = id; r.err = err; r.acquired = acq; r.completion = comp;
		r.status = st; r.flushed = fl; r.last = lst;
		due_results.insert(due_results.size(), r);
	endtask

	// producer-rule violations are silenced when checking is off
	task automatic post_producer_error(input logic [31:0] id, input err_t code);
		post_result(id, mdl_checks ? code : ERR_OK, 0, 0, 0, 0, 1);
	endtask

	task automatic track_command(input command_t c);
		int s, fr, hd;
		logic comp;
		s = -1;
		fr = -1;
		for (int i = 0; i < 16; i++) begin
			if (s < 0 && mdl_valid[i] && mdl_id[i] == c.id) s = i;
			if (fr < 0 && !mdl_valid[i]) fr = i;
		end
		case (c.cmd)
			CMD_ADD: begin
				if (s >= 0) post_producer_error(c.id, ERR_ADD_DUP);
				else if (fr < 0) post_result(c.id, ERR_POOL_FULL, 0, 0, 0, 0, 1);
				else begin
					mdl_valid[fr] = 1;
					mdl_id[fr] = c.id;
					mdl_pend[fr] = 0;
					if (mdl_producer_side) begin
						mdl_place[fr] = PLACE_PROD_WAIT;
						mdl_prod_q.insert(mdl_prod_q.size(), fr);
					end else begin
						mdl_place[fr] = PLACE_PROD_HELD;
					end
					post_result(c.id, ERR_OK, 0, 0, 0, 0, 1);
				end
			end
			CMD_REMOVE: begin
				if (s < 0) post_producer_error(c.id, ERR_REMOVE_ABSENT);
				else if (mdl_place[s] inside {PLACE_CONS_WAIT, PLACE_CONS_HELD})
					post_producer_error(c.id, ERR_REMOVE_PRESENTED);
				else begin
					if (mdl_place[s] == PLACE_PROD_WAIT)
						for (int j = mdl_prod_q.size() - 1; j >= 0; j--)
							if (mdl_prod_q[j] == s) mdl_prod_q.delete(j);
					mdl_valid[s] = 0;
					mdl_pend[s] = 0;
					post_result(c.id, ERR_OK, 0, 0, 0, 0, 1);
				end
			end
			CMD_ACQUIRE: begin
				if (mdl_producer_side ? mdl_prod_q.size() == 0 : mdl_cons_q.size() == 0)
					post_result(0, ERR_OK, 0, 0, 0, 0, 1);
				else begin
					if (mdl_producer_side) begin
						hd = mdl_prod_q[0];
						mdl_prod_q.delete(0);
					end else begin
						hd = mdl_cons_q[0];
						mdl_cons_q.delete(0);
					end
					mdl_place[hd] = mdl_producer_side ? PLACE_PROD_HELD : PLACE_CONS_HELD;
					post_result(mdl_id[hd], ERR_OK, 1, 0, 0, 0, 1);
				end
			end
			CMD_PRESENT: begin
				if (s < 0) post_producer_error(c.id, ERR_PRESENT_ABSENT);
				else if (mdl_place[s] == PLACE_PROD_WAIT)
					post_producer_error(c.id, ERR_PRESENT_NOT_ACQUIRED);
				else if (mdl_place[s] != PLACE_PROD_HELD)
					post_producer_error(c.id, ERR_PRESENT_PRESENTED);
				else begin
					if (mdl_producer_side) mdl_place[s] = PLACE_CONS_HELD;
					else begin
						mdl_place[s] = PLACE_CONS_WAIT;
						mdl_cons_q.insert(mdl_cons_q.size(), s);
					end
					mdl_pend[s] = 1;
					post_result(c.id, ERR_OK, 0, 0, 0, 0, 1);
				end
			end
			CMD_RELEASE: begin
				if (s < 0) post_result(c.id, ERR_RELEASE_ABSENT, 0, 0, 0, 0, 1);
				else if (mdl_place[s] == PLACE_CONS_WAIT)
					post_result(c.id, ERR_RELEASE_NOT_ACQUIRED, 0, 0, 0, 0, 1);
				else if (mdl_place[s] != PLACE_CONS_HELD)
					post_result(c.id, ERR_RELEASE_NOT_PRESENTED, 0, 0, 0, 0, 1);
				else begin
					if (mdl_producer_side) begin
						mdl_place[s] = PLACE_PROD_WAIT;
						mdl_prod_q.insert(mdl_prod_q.size(), s);
					end else begin
						mdl_place[s] = PLACE_PROD_HELD;
					end
					comp = mdl_pend[s];
					mdl_pend[s] = 0;
					post_result(c.id, ERR_OK, 0, comp, comp ? c.st : 3'd0, 0, 1);
				end
			end
			CMD_FLUSH: begin
				if (mdl_producer_side || mdl_cons_q.size() == 0)
					post_result(0, ERR_OK, 0, 0, 0, 0, 1);
				else begin
					// the pool holds 16 slots, so one flush always drains the queue
					for (int j = 0; j < mdl_cons_q.size(); j++) begin
						hd = mdl_cons_q[j];
						comp = mdl_pend[hd];
						mdl_place[hd] = PLACE_PROD_HELD;
						mdl_pend[hd] = 0;
						post_result(mdl_id[hd], ERR_OK, 0, comp, 0, comp,
							j == mdl_cons_q.size() - 1);
					end
					mdl_cons_q = {};
				end
			end
			default: post_result(c.id, ERR_OK, 0, 0, 0, 0, 1);
		endcase
	endtask

	function automatic command_t mk(input cmd_t cmd, input logic [31:0] id,
			input logic [2:0] st);
		command_t c;
		c.cmd = cmd; c.id = id; c.st = st;
		return c;
	endfunction

	task automatic queue_cmd(input command_t c);
		command_q.insert(command_q.size(), c);
	endtask

	// mostly complete handoff cycles for the current side, the rest noise
	task automatic queue_random(input int count);
		logic [31:0] id;
		cmd_t cmd;
		for (int n = 0; n < count; ) begin
			id = id_pool[$urandom_range(11)];
			if ($urandom_range(99) < 65) begin
				queue_cmd(mk(CMD_ADD, id, 0));
				if (mdl_producer_side) queue_cmd(mk(CMD_ACQUIRE, 0, 0));
				queue_cmd(mk(CMD_PRESENT, id, 0));
				if (!mdl_producer_side) queue_cmd(mk(CMD_ACQUIRE, 0, 0));
				if ($urandom_range(3) == 0) queue_cmd(mk(CMD_FLUSH, 0, 0));
				queue_cmd(mk(CMD_RELEASE, id, $urandom_range(7)));
				if ($urandom_range(1)) queue_cmd(mk(CMD_REMOVE, id, 0));
				n += 5;
			end else begin
				cmd = cmd_t'($urandom_range(5));
				if ($urandom_range(9) == 0) id = $urandom;
				queue_cmd(mk(cmd, id, $urandom_range(7)));
				n += 1;
			end
		end
	endtask

	// hold the sender until nothing is owed, then let the block settle
	task automatic drain;
		@(negedge clk);
		while (command_q.size() != 0 || s_tvalid || due_results.size() != 0)
			@(negedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_PRODUCER_SIDE) mdl_producer_side = val;
		else mdl_checks = val;
	endtask

	// driver: predict on every accepted transaction, then offer the next one
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) track_command(drv_item);
			if (!s_tvalid || s_tready) begin
				if (command_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					drv_item = command_q[0];
					command_q.delete(0);
					s_tvalid <= 1'b1;
					s_tdata <= {2'b00, drv_item.st, drv_item.id, drv_item.cmd};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stalls, plus one long hold-off to back the block up
	int  stall_left;
	logic held_once;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
			held_once = 1'b0;
		end else begin
			if (!held_once && accepted_results == 30) begin
				held_once = 1'b1;
				stall_left = 400;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// monitor: compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		res_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			accepted_results++;
			if (due_results.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h last %b", m_tdata, m_tlast);
			end else begin
				exp_r = due_results[0];
				due_results.delete(0);
				if (m_tdata[31:0] !== exp_r.id || m_tdata[35:32] !== exp_r.err ||
						m_tdata[36] !== exp_r.acquired || m_tdata[37] !== exp_r.completion ||
						m_tdata[40:38] !== exp_r.status || m_tdata[41] !== exp_r.flushed ||
						m_tdata[47:42] !== 6'd0 || m_tlast !== exp_r.last) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp id %h err %0d acq %b comp %b st %0d fl %b last %b",
							exp_r.id, exp_r.err, exp_r.acquired, exp_r.completion,
							exp_r.status, exp_r.flushed, exp_r.last,
							" / got id %h err %0d acq %b comp %b st %0d fl %b last %b",
							m_tdata[31:0], m_tdata[35:32], m_tdata[36], m_tdata[37],
							m_tdata[40:38], m_tdata[41], m_tlast);
				end
			end
		end
	end

	initial begin
		logic [31:0] a, b;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		accepted_results = 0;
		send_idle_pct = 34;
		recv_idle_pct = 68;
		mdl_producer_side = 0;
		mdl_checks = 1;
		for (int i = 0; i < 16; i++) begin
			mdl_valid[i] = 0;
			mdl_pend[i] = 0;
			mdl_place[i] = PLACE_PROD_WAIT;
			mdl_id[i] = '0;
		end
		a = 32'h0000_0000;
		b = 32'hFFFF_FFFF;
		id_pool[0] = a;
		id_pool[1] = b;
		for (int i = 2; i < 12; i++) id_pool[i] = $urandom;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// consumer end, checks on: walk each rule once, save pool full and present-not-acquired
		write_reg(CFG_PRODUCER_SIDE, 1'b0);
		write_reg(CFG_CHECKS, 1'b1);
		queue_cmd(mk(CMD_ACQUIRE, 0, 0));        // empty queue
		queue_cmd(mk(CMD_FLUSH, 0, 0));          // nothing to flush
		queue_cmd(mk(CMD_ADD, a, 0));
		queue_cmd(mk(CMD_ADD, a, 0));            // duplicate
		queue_cmd(mk(CMD_PRESENT, a, 0));
		queue_cmd(mk(CMD_REMOVE, a, 0));         // still presented
		queue_cmd(mk(CMD_PRESENT, a, 0));        // already presented
		queue_cmd(mk(CMD_RELEASE, a, 0));        // waiting, not acquired
		queue_cmd(mk(CMD_FLUSH, 0, 0));          // completes a, flushed
		queue_cmd(mk(CMD_PRESENT, a, 0));
		queue_cmd(mk(CMD_ACQUIRE, 0, 0));
		queue_cmd(mk(CMD_RELEASE, a, 3'd7));
		queue_cmd(mk(CMD_RELEASE, a, 3'd0));     // not presented
		queue_cmd(mk(CMD_ADD, b, 0));
		queue_cmd(mk(CMD_REMOVE, b, 0));
		queue_cmd(mk(CMD_REMOVE, b, 0));         // absent
		queue_cmd(mk(CMD_PRESENT, b, 0));        // absent
		queue_cmd(mk(CMD_RELEASE, b, 3'd5));     // absent
		queue_cmd(mk(CMD_REMOVE, a, 0));
		queue_random(24);
		drain();

		// producer end, then consumer end, checks silenced
		send_idle_pct = 68;
		recv_idle_pct = 34;
		write_reg(CFG_PRODUCER_SIDE, 1'b1);
		write_reg(CFG_CHECKS, 1'b0);
		queue_random(20);
		drain();
		write_reg(CFG_PRODUCER_SIDE, 1'b0);
		queue_random(12);
		drain();

		// producer end, checks on, no idling; overfill the pool at the end
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(CFG_PRODUCER_SIDE, 1'b1);
		write_reg(CFG_CHECKS, 1'b1);
		queue_cmd(mk(CMD_ADD, 32'h1234_5678, 0));
		queue_cmd(mk(CMD_PRESENT, 32'h1234_5678, 0)); // still waiting
		queue_random(16);
		for (int i = 0; i < 17; i++) queue_cmd(mk(CMD_ADD, $urandom, 0));
		queue_cmd(mk(CMD_ACQUIRE, 0, 0));
		drain();

		if (errors == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule
